// ----- rtl/twc_pkg.sv -----
// twc_pkg: shared types and helpers for the triangle waterline clipper
// no dependencies; imported by twc_front, twc_back, the top level and the testbench
`default_nettype none
package twc_pkg;

  localparam int COORD_W = 32;
  localparam int HGT_W = COORD_W + 1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [HGT_W-1:0] hgt_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vtx_t;

  typedef enum logic [1:0] {
    MODE_PASS,
    MODE_ONE_UP,
    MODE_TWO_UP
  } mode_t;

  // vh/vm/vl are the high, middle and low roles; in pass mode they are v2, v1, v0
  typedef struct packed {
    vtx_t vh;
    vtx_t vm;
    vtx_t vl;
    hgt_t hh;
    hgt_t hm;
    hgt_t hl;
    mode_t mode;
    logic sub;
  } entry_t;

  function automatic coord_t get_c(input vtx_t v, input logic [1:0] k);
    coord_t r;
    case (k)
      2'd0: r = v.x;
      2'd1: r = v.y;
      default: r = v.z;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/twc_front.sv -----
// twc_front: computes vertex heights and sorts vertices into clip roles
// depends on twc_pkg
`default_nettype none
module twc_front
  import twc_pkg::*;
(
  input  vtx_t   v0,
  input  vtx_t   v1,
  input  vtx_t   v2,
  input  coord_t water_level,
  output entry_t ent
);

  vtx_t v [3];
  hgt_t h [3];
  logic [2:0] up;
  logic [1:0] nup;
  logic [1:0] ih, im, il;

  always_comb begin
    v[0] = v0;
    v[1] = v1;
    v[2] = v2;
    for (int i = 0; i < 3; i++) begin
      h[i] = HGT_W'(v[i].z) - HGT_W'(water_level);
      up[i] = ~h[i][HGT_W-1];
    end
    nup = 2'(up[0]) + 2'(up[1]) + 2'(up[2]);
    ih = 2'd2;
    im = 2'd1;
    il = 2'd0;
    ent.mode = MODE_PASS;
    if (nup == 2'd1) begin
      ent.mode = MODE_ONE_UP;
      if (up[0]) begin
        ih = 2'd0; im = 2'd2; il = 2'd1;
      end else if (up[1]) begin
        ih = 2'd1; im = 2'd0; il = 2'd2;
      end else begin
        ih = 2'd2; im = 2'd1; il = 2'd0;
      end
    end else if (nup == 2'd2) begin
      ent.mode = MODE_TWO_UP;
      if (!up[0]) begin
        il = 2'd0; ih = 2'd1; im = 2'd2;
      end else if (!up[1]) begin
        il = 2'd1; ih = 2'd2; im = 2'd0;
      end else begin
        il = 2'd2; ih = 2'd0; im = 2'd1;
      end
    end
    ent.vh = v[ih];
    ent.vm = v[im];
    ent.vl = v[il];
    ent.hh = h[ih];
    ent.hm = h[im];
    ent.hl = h[il];
    ent.sub = (nup == 2'd0);
  end

endmodule
`default_nettype wire

// ----- rtl/twc_queue.sv -----
// twc_queue: two-entry queue between the classifier and the clipping engine
// no package dependencies
`default_nettype none
module twc_queue #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] wdata,
  output logic              full,
  output logic              nonempty,
  input  logic              pop,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2];
  logic wptr, rptr;
  logic [1:0] count;

  assign full = (count == 2'd2);
  assign nonempty = (count != 2'd0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/twc_back.sv -----
// twc_back: cuts crossing edges (shared-step dividers, multipliers) and emits pieces
// depends on twc_pkg
`default_nettype none
module twc_back
  import twc_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int INDEX_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  entry_t                q_ent,
  input  logic [INDEX_BITS-1:0] q_idx,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output vtx_t                  o0,
  output vtx_t                  o1,
  output vtx_t                  o2,
  output logic                  o_sub,
  output logic [INDEX_BITS-1:0] o_idx,
  output logic                  o_last
);

  localparam int DEN_W = HGT_W + 1;
  localparam int REM_W = DEN_W + 1;
  localparam int T_W = FRAC_BITS + 1;
  localparam int CNT_W = $clog2(FRAC_BITS + 1);
  localparam int PROD_W = T_W + 1 + HGT_W;
  localparam logic [T_W-1:0] T_ONE = T_W'(1) << FRAC_BITS;

  typedef enum logic [2:0] {S_IDLE, S_SETUP, S_DIV, S_MUL, S_EMIT} state_t;

  state_t state;
  entry_t ent;
  logic [INDEX_BITS-1:0] idx;
  logic [CNT_W-1:0] cnt;
  logic [1:0] k;
  logic [1:0] piece;
  logic [REM_W-1:0] rem_p, rem_q;
  logic [DEN_W-1:0] den_p, den_q;
  logic [T_W-1:0] tq_p, tq_q;
  logic full_p, full_q;
  vtx_t cp, cq;

  vtx_t bp, ap, bq, aq;
  hgt_t hbp, hap, hbq, haq;
  logic [DEN_W-1:0] np_c, nq_c, dp_c, dq_c;
  logic [REM_W-1:0] r2p, r2q;
  logic [T_W-1:0] tp, tt;
  logic signed [HGT_W-1:0] dpk, dqk;
  logic signed [PROD_W-1:0] prp, prq;
  coord_t rp, rq;
  vtx_t p0, p1, p2;
  logic psub, plast, emit;

  assign q_pop = (state == S_IDLE) && q_valid;
  assign emit = (state == S_EMIT) && (!out_valid || out_ready);

  always_comb begin
    if (ent.mode == MODE_ONE_UP) begin
      bp = ent.vm; hbp = ent.hm; ap = ent.vh; hap = ent.hh;
    end else begin
      bp = ent.vl; hbp = ent.hl; ap = ent.vm; hap = ent.hm;
    end
    bq = ent.vl; hbq = ent.hl; aq = ent.vh; haq = ent.hh;
    np_c = -DEN_W'(hbp);
    nq_c = -DEN_W'(hbq);
    dp_c = DEN_W'(hap) - DEN_W'(hbp);
    dq_c = DEN_W'(haq) - DEN_W'(hbq);
    r2p = {rem_p[REM_W-2:0], 1'b0};
    r2q = {rem_q[REM_W-2:0], 1'b0};
    tp = full_p ? T_ONE : tq_p;
    tt = full_q ? T_ONE : tq_q;
    dpk = HGT_W'(get_c(ap, k)) - HGT_W'(get_c(bp, k));
    dqk = HGT_W'(get_c(aq, k)) - HGT_W'(get_c(bq, k));
    prp = $signed({1'b0, tp}) * dpk;
    prq = $signed({1'b0, tt}) * dqk;
    rp = get_c(bp, k) + COORD_W'(prp >>> FRAC_BITS);
    rq = get_c(bq, k) + COORD_W'(prq >>> FRAC_BITS);
  end

  always_comb begin
    p0 = ent.vh; p1 = ent.vm; p2 = ent.vl; psub = ent.sub; plast = 1'b1;
    case (ent.mode)
      MODE_ONE_UP: begin
        case (piece)
          2'd0: begin p0 = cq; p1 = cp; p2 = ent.vm; psub = 1'b1; plast = 1'b0; end
          2'd1: begin p0 = ent.vl; p1 = cq; p2 = ent.vm; psub = 1'b1; plast = 1'b0; end
          default: begin p0 = cq; p1 = ent.vh; p2 = cp; psub = 1'b0; plast = 1'b1; end
        endcase
      end
      MODE_TWO_UP: begin
        case (piece)
          2'd0: begin p0 = cp; p1 = cq; p2 = ent.vl; psub = 1'b1; plast = 1'b0; end
          2'd1: begin p0 = cp; p1 = ent.vh; p2 = cq; psub = 1'b0; plast = 1'b0; end
          default: begin p0 = ent.vm; p1 = ent.vh; p2 = cp; psub = 1'b0; plast = 1'b1; end
        endcase
      end
      default: begin
        p0 = ent.vh; p1 = ent.vm; p2 = ent.vl; psub = ent.sub; plast = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      cnt <= '0;
      k <= 2'd0;
      piece <= 2'd0;
    end else begin
      if (out_valid && out_ready && !emit) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            ent <= q_ent;
            idx <= q_idx;
            piece <= 2'd0;
            state <= (q_ent.mode == MODE_PASS) ? S_EMIT : S_SETUP;
          end
        end
        S_SETUP: begin
          rem_p <= REM_W'(np_c);
          rem_q <= REM_W'(nq_c);
          den_p <= dp_c;
          den_q <= dq_c;
          full_p <= (np_c == dp_c);
          full_q <= (nq_c == dq_c);
          tq_p <= '0;
          tq_q <= '0;
          cnt <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (r2p >= REM_W'(den_p)) begin
            rem_p <= r2p - REM_W'(den_p);
            tq_p <= {tq_p[T_W-2:0], 1'b1};
          end else begin
            rem_p <= r2p;
            tq_p <= {tq_p[T_W-2:0], 1'b0};
          end
          if (r2q >= REM_W'(den_q)) begin
            rem_q <= r2q - REM_W'(den_q);
            tq_q <= {tq_q[T_W-2:0], 1'b1};
          end else begin
            rem_q <= r2q;
            tq_q <= {tq_q[T_W-2:0], 1'b0};
          end
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(FRAC_BITS - 1)) begin
            k <= 2'd0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          case (k)
            2'd0: begin cp.x <= rp; cq.x <= rq; end
            2'd1: begin cp.y <= rp; cq.y <= rq; end
            default: begin cp.z <= rp; cq.z <= rq; end
          endcase
          k <= k + 2'd1;
          if (k == 2'd2) state <= S_EMIT;
        end
        S_EMIT: begin
          if (emit) begin
            out_valid <= 1'b1;
            o0 <= p0;
            o1 <= p1;
            o2 <= p2;
            o_sub <= psub;
            o_idx <= idx;
            o_last <= plast;
            piece <= piece + 2'd1;
            if (plast) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/triangle_waterline_clipper_unit.sv -----
// triangle_waterline_clipper_unit: top level, apb register, classifier, queue, engine
// depends on twc_pkg, twc_front, twc_queue, twc_back
//
// usage: one triangle (three Q16.16 vertices and an index) is a transfer on the
// in_valid/in_ready channel; it yields 1 or 3 triangles on out_valid/out_ready,
// each tagged submerged or above, last_piece marks the final one of a triangle.
// water_level is written over the apb port (address 0); the user must write it
// only while the block is idle, which the block itself does not enforce. the
// classifier sorts vertices by side and ring order and pushes a two-entry queue;
// in_ready is high while that queue has room. a triangle wholly on one side is
// queued, popped by the engine and emitted as one piece; a split triangle is
// popped, set up, divided (one quotient bit per cycle in two parallel dividers),
// multiplied one coordinate at a time and then emitted one piece per cycle while
// the receiver is ready. the engine finishes a triangle before it pops the next.
// a stalled receiver holds the output register; the engine and then the queue
// fill, and in_ready falls. reset empties queue and engine, water_level is 0.
`default_nettype none
module triangle_waterline_clipper_unit
  import twc_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int INDEX_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  coord_t                v0_x,
  input  coord_t                v0_y,
  input  coord_t                v0_z,
  input  coord_t                v1_x,
  input  coord_t                v1_y,
  input  coord_t                v1_z,
  input  coord_t                v2_x,
  input  coord_t                v2_y,
  input  coord_t                v2_z,
  input  logic [INDEX_BITS-1:0] tri_index,
  output logic                  out_valid,
  input  logic                  out_ready,
  output coord_t                out0_x,
  output coord_t                out0_y,
  output coord_t                out0_z,
  output coord_t                out1_x,
  output coord_t                out1_y,
  output coord_t                out1_z,
  output coord_t                out2_x,
  output coord_t                out2_y,
  output coord_t                out2_z,
  output logic                  submerged,
  output logic [INDEX_BITS-1:0] source_index,
  output logic                  last_piece
);

  localparam int ENT_W = $bits(entry_t);
  localparam int Q_W = ENT_W + INDEX_BITS;

  coord_t water_level;
  entry_t f_ent, q_ent;
  logic q_full, q_nonempty, q_pop, push;
  logic [Q_W-1:0] q_rdata;
  vtx_t o0, o1, o2;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : water_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      water_level <= '0;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      water_level <= pwdata;
    end
  end

  twc_front u_front (
    .v0('{x: v0_x, y: v0_y, z: v0_z}),
    .v1('{x: v1_x, y: v1_y, z: v1_z}),
    .v2('{x: v2_x, y: v2_y, z: v2_z}),
    .water_level(water_level),
    .ent(f_ent)
  );

  assign in_ready = !q_full;
  assign push = in_valid && !q_full;

  twc_queue #(.DATA_W(Q_W)) u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .wdata({tri_index, f_ent}),
    .full(q_full),
    .nonempty(q_nonempty),
    .pop(q_pop),
    .rdata(q_rdata)
  );

  assign q_ent = q_rdata[ENT_W-1:0];

  twc_back #(.FRAC_BITS(FRAC_BITS), .INDEX_BITS(INDEX_BITS)) u_back (
    .clk(clk),
    .rst(rst),
    .q_valid(q_nonempty),
    .q_ent(q_ent),
    .q_idx(q_rdata[Q_W-1:ENT_W]),
    .q_pop(q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .o0(o0),
    .o1(o1),
    .o2(o2),
    .o_sub(submerged),
    .o_idx(source_index),
    .o_last(last_piece)
  );

  assign out0_x = o0.x;
  assign out0_y = o0.y;
  assign out0_z = o0.z;
  assign out1_x = o1.x;
  assign out1_y = o1.y;
  assign out1_z = o1.z;
  assign out2_x = o2.x;
  assign out2_y = o2.y;
  assign out2_z = o2.z;

endmodule
`default_nettype wire

// ----- rtl/twc_checker.sv -----
// twc_checker: port-level checks on the clipper's result channel
// bound to triangle_waterline_clipper_unit; no package dependencies
`default_nettype none
module twc_checker #(
  parameter int INDEX_BITS = 16
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic                  last_piece,
  input logic [INDEX_BITS-1:0] source_index
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_reset_ready: assert property (@(posedge clk) rst |=> in_ready)
    else $error("input not ready after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(last_piece) && $stable(source_index))
    else $error("stalled result changed");

endmodule

bind triangle_waterline_clipper_unit twc_checker #(.INDEX_BITS(INDEX_BITS)) u_twc_checker (.*);
`default_nettype wire

// ----- test/testbench.sv -----
// testbench: self-checking bench for triangle_waterline_clipper_unit
// depends on twc_pkg and the clipper rtl; splits are checked against an in-bench predictor
`default_nettype none
module testbench;
  import twc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 16;
  localparam int IDXW = 16;
  localparam int DRAIN = FRAC + 24;
  localparam int WATCHDOG = 3000;
  localparam logic [2:0] ADDR_WATER_LEVEL = 3'd0;
  localparam logic [2:0] ADDR_UNUSED = 3'd4;
  localparam int NFIELD = 12;

  typedef struct {
    longint c[3];
  } point_t;

  typedef struct {
    logic [31:0] f[NFIELD];
  } piece_t;

  typedef struct {
    logic [31:0] v[9];
    logic [15:0] idx;
    bit          typed;
    bit          sub;
  } row_t;

  logic clk, rst;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic in_valid, in_ready, out_valid, out_ready;
  coord_t v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z;
  logic [IDXW-1:0] tri_index;
  coord_t out0_x, out0_y, out0_z, out1_x, out1_y, out1_z, out2_x, out2_y, out2_z;
  logic submerged, last_piece;
  logic [IDXW-1:0] source_index;

  piece_t expected_pieces[$];
  longint water_level;
  int idle_in, stall_out;
  int errors, quiet_cycles;
  bit cur_typed, cur_sub;

  string field_names[NFIELD] = '{"out0_x", "out0_y", "out0_z", "out1_x", "out1_y", "out1_z",
                                 "out2_x", "out2_y", "out2_z", "submerged", "source_index",
                                 "last_piece"};

  triangle_waterline_clipper_unit #(.FRAC_BITS(FRAC), .INDEX_BITS(IDXW)) DUT (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic point_t cut_edge(point_t b, longint hb, point_t a, longint ha);
    point_t r;
    longint t;
    t = ((-hb) <<< FRAC) / (ha - hb);
    for (int k = 0; k < 3; k++) r.c[k] = b.c[k] + ((t * (a.c[k] - b.c[k])) >>> FRAC);
    return r;
  endfunction

  function automatic void push_piece(point_t p0, point_t p1, point_t p2, bit sub,
                                     logic [15:0] idx, bit last);
    piece_t p;
    for (int k = 0; k < 3; k++) begin
      p.f[k] = p0.c[k][31:0];
      p.f[3+k] = p1.c[k][31:0];
      p.f[6+k] = p2.c[k][31:0];
    end
    p.f[9] = sub;
    p.f[10] = idx;
    p.f[11] = last;
    expected_pieces.push_back(p);
  endfunction

  function automatic void predict_split(logic [31:0] v[9], logic [15:0] idx);
    point_t p[3], ca, cb;
    longint h[3];
    bit up[3];
    int nup, ih, im, il;
    nup = 0;
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) p[i].c[k] = longint'(signed'(v[3*i+k]));
      h[i] = p[i].c[2] - water_level;
      up[i] = h[i] >= 0;
      nup += up[i];
    end
    if (nup == 0 || nup == 3) begin
      push_piece(p[2], p[1], p[0], nup == 0, idx, 1);
    end else if (nup == 1) begin
      ih = up[0] ? 0 : (up[1] ? 1 : 2);
      im = (ih + 2) % 3;
      il = (ih + 1) % 3;
      ca = cut_edge(p[im], h[im], p[ih], h[ih]);
      cb = cut_edge(p[il], h[il], p[ih], h[ih]);
      push_piece(cb, ca, p[im], 1, idx, 0);
      push_piece(p[il], cb, p[im], 1, idx, 0);
      push_piece(cb, p[ih], ca, 0, idx, 1);
    end else begin
      il = !up[0] ? 0 : (!up[1] ? 1 : 2);
      ih = (il + 1) % 3;
      im = (il + 2) % 3;
      ca = cut_edge(p[il], h[il], p[im], h[im]);
      cb = cut_edge(p[il], h[il], p[ih], h[ih]);
      push_piece(ca, cb, p[il], 1, idx, 0);
      push_piece(ca, p[ih], cb, 0, idx, 0);
      push_piece(p[im], p[ih], ca, 0, idx, 1);
    end
  endfunction

  always @(posedge clk) begin
    piece_t got, want;
    logic [31:0] v[9];
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
        $display("*** FAILED ***");
        $finish;
      end
      if (in_valid && in_ready) begin
        v = '{v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z};
        if (cur_typed) begin
          for (int k = 0; k < 3; k++) begin
            want.f[k] = v[6+k];
            want.f[3+k] = v[3+k];
            want.f[6+k] = v[k];
          end
          want.f[9] = cur_sub;
          want.f[10] = tri_index;
          want.f[11] = 1;
          expected_pieces.push_back(want);
        end else begin
          predict_split(v, tri_index);
        end
      end
      if (out_valid && out_ready) begin
        got.f = '{out0_x, out0_y, out0_z, out1_x, out1_y, out1_z, out2_x, out2_y, out2_z,
                  32'(submerged), 32'(source_index), 32'(last_piece)};
        if (expected_pieces.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected output transfer");
        end else begin
          want = expected_pieces.pop_front();
          for (int k = 0; k < NFIELD; k++)
            if (got.f[k] !== want.f[k]) begin
              errors++;
              if (errors <= 10)
                $display("mismatch %s: expected %h got %h", field_names[k], want.f[k],
                         got.f[k]);
            end
        end
      end
    end
  end

  always @(negedge clk) out_ready <= rst ? 1'b0 : ($urandom_range(99) >= stall_out);

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= data;
    @(negedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (addr == ADDR_WATER_LEVEL) water_level = longint'(signed'(data));
  endtask

  task automatic apb_check(input logic [31:0] want);
    @(negedge clk);
    psel <= 1; penable <= 0; pwrite <= 0; paddr <= ADDR_WATER_LEVEL;
    @(negedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== want) begin
      errors++;
      if (errors <= 10) $display("water_level readback: expected %h got %h", want, prdata);
    end
    @(negedge clk);
    psel <= 0; penable <= 0;
  endtask

  task automatic send_triangle(input row_t r);
    while ($urandom_range(99) < idle_in) begin
      in_valid <= 0;
      @(negedge clk);
    end
    {v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z} <=
        {r.v[0], r.v[1], r.v[2], r.v[3], r.v[4], r.v[5], r.v[6], r.v[7], r.v[8]};
    tri_index <= r.idx;
    cur_typed <= r.typed;
    cur_sub <= r.sub;
    in_valid <= 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 0;
    while (expected_pieces.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  function automatic logic [31:0] random_height();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return $urandom;
    if (sel == 1) return water_level[31:0];
    if (sel < 6) return water_level[31:0] + $urandom_range(32'h0004_0000);
    return water_level[31:0] - $urandom_range(32'h0004_0000);
  endfunction

  localparam logic [31:0] MN = 32'h8000_0000;
  localparam logic [31:0] MX = 32'h7fff_ffff;
  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam logic [31:0] NEG = 32'hffff_0000;

  row_t directed[18] = '{
    '{'{ONE, 2*ONE, ONE, 3*ONE, ONE, 2*ONE, 5, 6, 3*ONE}, 16'h0000, 1, 0},
    '{'{ONE, 2*ONE, NEG, 3*ONE, ONE, 2*NEG, 5, 6, 3*NEG}, 16'hffff, 1, 1},
    '{'{MN, MX, MX, MX, MN, MX, MN, MN, MX}, 16'h1234, 1, 0},
    '{'{MN, MN, MN, MN, MN, MN, MN, MN, MN}, 16'hffff, 1, 1},
    '{'{MX, MX, 0, MX, MX, 0, MX, MX, 0}, 16'h0001, 1, 0},
    '{'{0, 0, ONE, ONE, 0, NEG, 0, ONE, 2*NEG}, 16'h0002, 0, 0},
    '{'{0, 0, NEG, ONE, 0, ONE, 0, ONE, 2*NEG}, 16'h0003, 0, 0},
    '{'{0, 0, NEG, ONE, 0, 3*NEG, 0, ONE, ONE}, 16'h0004, 0, 0},
    '{'{0, 0, NEG, ONE, 0, ONE, 0, ONE, 2*ONE}, 16'h0005, 0, 0},
    '{'{0, 0, ONE, ONE, 0, NEG, 0, ONE, 2*ONE}, 16'h0006, 0, 0},
    '{'{0, 0, ONE, ONE, 0, 2*ONE, 0, ONE, NEG}, 16'h0007, 0, 0},
    '{'{5*ONE, NEG, 0, ONE, 0, NEG, 0, ONE, 2*NEG}, 16'h0008, 0, 0},
    '{'{MN, MX, MX, MX, MN, MN, MN, MX, MN}, 16'h8000, 0, 0},
    '{'{MX, MN, MN, MN, MX, MX, MX, MN, MX}, 16'h7fff, 0, 0},
    '{'{MN, MN, MN, MX, MX, MX, MN, MX, 0}, 16'haaaa, 0, 0},
    '{'{MX, MX, 32'hffff_ffff, MN, MN, 0, 0, 0, 0}, 16'h5555, 0, 0},
    '{'{3, 7, 32'hffff_ffff, 32'hffff_fff0, 11, 1, 2, MX, 32'hffff_ffff}, 16'h00ff, 0, 0},
    '{'{ONE, ONE, MX, NEG, NEG, MN, 0, 0, MX}, 16'hff00, 0, 0}
  };

  logic [31:0] levels[6] = '{32'h0000_0000, MN, MX, 32'h0003_8000, 32'hfff0_4000, 32'h0};

  initial begin
    row_t r;
    rst = 1;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    in_valid = 0; out_ready = 0; tri_index = 0; cur_typed = 0; cur_sub = 0;
    {v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z} = '0;
    water_level = 0; idle_in = 0; stall_out = 0; errors = 0; quiet_cycles = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;
    apb_check(32'h0);
    foreach (directed[i]) send_triangle(directed[i]);
    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      levels[5] = $urandom;
      apb_write(ADDR_WATER_LEVEL, levels[ph]);
      apb_write(ADDR_UNUSED, $urandom);
      apb_check(levels[ph]);
      idle_in = (ph % 4 == 1 || ph % 4 == 3) ? (ph % 4 == 1 ? 73 : 33) : 0;
      stall_out = (ph % 4 == 2 || ph % 4 == 3) ? (ph % 4 == 2 ? 73 : 33) : 0;
      for (int n = 0; n < 56; n++) begin
        if (ph == 3 && n == 28) wait_idle();
        r.typed = 0;
        r.sub = 0;
        r.idx = $urandom;
        for (int i = 0; i < 3; i++) begin
          r.v[3*i] = $urandom;
          r.v[3*i+1] = $urandom;
          r.v[3*i+2] = random_height();
        end
        send_triangle(r);
      end
    end
    idle_in = 0;
    stall_out = 0;
    wait_idle();
    if (errors == 0 && expected_pieces.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire
